/* rtl/core/dtu_pkg.sv */
// Package for the decimal text to unsigned converter.
// Holds the payload types, status, width and character codes, the byte class helpers and the width check.
// No dependencies; the interfaces and the top level import it.
package dtu_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [63:0] value_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  width_code_t;

  // Result status codes.
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_RANGE   = 2'd2;

  // Target width codes.
  localparam width_code_t WIDTH_8  = 2'd0;
  localparam width_code_t WIDTH_16 = 2'd1;
  localparam width_code_t WIDTH_32 = 2'd2;
  localparam width_code_t WIDTH_64 = 2'd3;

  // Character codes.
  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_TAB   = 8'h09;
  localparam char_t CHAR_CR    = 8'h0D;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;

  // Space, tab, newline, vertical tab, form feed or carriage return.
  function automatic logic is_space(input char_t c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // True when the value does not fit in the selected target width.
  function automatic logic exceeds_width(input value_t v, input width_code_t code);
    logic res;
    case (code)
      WIDTH_8:  res = |v[63:8];
      WIDTH_16: res = |v[63:16];
      WIDTH_32: res = |v[63:32];
      default:  res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/dtu_char_if.sv */
// Input channel of the decimal text converter: one text byte per item.
// Depends on dtu_pkg for the byte type.
interface dtu_char_if import dtu_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

/* rtl/core/dtu_result_if.sv */
// Result channel of the decimal text converter: value and status per item.
// Depends on dtu_pkg for the value and status types.
interface dtu_result_if import dtu_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  parsed_value;
  status_t parse_status;

  modport source (output valid, output parsed_value, output parse_status, input ready);
  modport sink   (input valid, input parsed_value, input parse_status, output ready);
endinterface

/* rtl/core/decimal_text_to_unsigned.sv */
// Decimal text to unsigned integer converter, top level.
// Depends on dtu_pkg, dtu_char_if and dtu_result_if.
//
// The block takes one text byte per cycle, one item per cycle, but holds a zero
// byte in the input register until the result register is free. A zero byte
// ends the string and produces one result, registered in the input register and
// then the result register; other bytes produce no result. The rate is set by the
// per-byte scan update, a times-ten add on the 64-bit accumulator and phase update.
// The width register (cfg_wdata, reset to 64 bit) is read when a string ends and
// should be written only while no string is in progress.
module decimal_text_to_unsigned import dtu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  dtu_char_if.sink            in_chan,
  dtu_result_if.source        out_chan,
  input  logic                cfg_we,
  input  width_code_t         cfg_wdata
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_JUNK   = 3'd4
  } phase_t;

  // Registers.
  width_code_t width_code_r;
  logic        s1_valid_r,  s1_valid_nxt;
  char_t       s1_byte_r,   s1_byte_nxt;
  phase_t      phase_r,     phase_nxt;
  value_t      acc_r,       acc_nxt;
  logic        ovf_r,       ovf_nxt;
  logic        minus_r,     minus_nxt;
  logic        any_r,       any_nxt;
  logic        out_valid_r, out_valid_nxt;
  value_t      out_value_r, out_value_nxt;
  status_t     out_status_r, out_status_nxt;

  logic        out_free;
  logic        is_term;
  logic        s1_fire;
  logic        in_fire;
  logic [3:0]  digit;
  logic [67:0] times_ten;
  logic        digit_ovf;
  value_t      acc_digit;
  logic        ovf_digit;

  // Handshake: the input register drains when its byte is not a terminator,
  // or when the result register can take the result.
  assign out_free     = !out_valid_r || out_chan.ready;
  assign is_term      = (s1_byte_r == CHAR_NUL);
  assign s1_fire      = s1_valid_r && (!is_term || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire      = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.parsed_value = out_value_r;
  assign out_chan.parse_status = out_status_r;

  // Times ten plus digit, with saturation once the run leaves 64 bits.
  assign digit     = s1_byte_r[3:0] - CHAR_ZERO[3:0];
  assign times_ten = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, digit};
  assign digit_ovf = ovf_r || (|times_ten[67:64]);
  assign ovf_digit = digit_ovf;
  assign acc_digit = digit_ovf ? {64{1'b1}} : times_ten[63:0];

  // Scan update and result formation.
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    s1_byte_nxt    = s1_byte_r;
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    minus_nxt      = minus_r;
    any_nxt        = any_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (is_term) begin
        // End of string: classify, emit and return to the start state.
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        if (!any_r || minus_r) begin
          out_status_nxt = STATUS_INVALID;
        end else if (ovf_r || exceeds_width(acc_r, width_code_r)) begin
          out_status_nxt = STATUS_RANGE;
        end else if (phase_r == PH_SIGN || phase_r == PH_JUNK) begin
          out_status_nxt = STATUS_INVALID;
        end else begin
          out_status_nxt = STATUS_OK;
          out_value_nxt  = acc_r;
        end
        phase_nxt = PH_LEAD;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        minus_nxt = 1'b0;
        any_nxt   = 1'b0;
      end else begin
        any_nxt = 1'b1;
        if (s1_byte_r == CHAR_MINUS) begin
          minus_nxt = 1'b1;
        end
        case (phase_r)
          PH_LEAD: begin
            if (is_space(s1_byte_r)) begin
              phase_nxt = PH_LEAD;
            end else if (s1_byte_r == CHAR_PLUS) begin
              phase_nxt = PH_SIGN;
            end else if (is_digit(s1_byte_r)) begin
              acc_nxt   = acc_digit;
              ovf_nxt   = ovf_digit;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_JUNK;
            end
          end
          PH_SIGN: begin
            if (is_digit(s1_byte_r)) begin
              acc_nxt   = acc_digit;
              ovf_nxt   = ovf_digit;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_JUNK;
            end
          end
          PH_DIGITS: begin
            if (is_digit(s1_byte_r)) begin
              acc_nxt = acc_digit;
              ovf_nxt = ovf_digit;
            end else if (is_space(s1_byte_r)) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_JUNK;
            end
          end
          PH_TRAIL: begin
            if (!is_space(s1_byte_r)) begin
              phase_nxt = PH_JUNK;
            end
          end
          default: begin
            phase_nxt = PH_JUNK;
          end
        endcase
      end
    end

    // Capture a new item into the input register.
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_chan.char_byte;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r <= WIDTH_64;
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_LEAD;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      minus_r      <= 1'b0;
      any_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_code_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      minus_r     <= minus_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_byte_r    <= s1_byte_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // A failed string never carries a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> (out_value_r == '0))
    else $error("nonzero value with failing status");

  // Status is always one of the three defined codes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == STATUS_OK || out_status_r == STATUS_INVALID ||
                     out_status_r == STATUS_RANGE))
    else $error("undefined status code");

  // A saturated digit run holds the all-ones value.
  assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (acc_r == {64{1'b1}}))
    else $error("overflow flag without saturated accumulator");

  // A terminator returns the scan to its start state and raises a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_term) |=> (out_valid_r && phase_r == PH_LEAD && acc_r == '0 &&
                              !any_r && !minus_r && !ovf_r))
    else $error("terminator did not close the string");

  // In the leading phase the accumulator is still zero and no overflow is flagged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAD) |-> (acc_r == '0 && !ovf_r))
    else $error("accumulator nonzero before the digit run");
`endif

endmodule
